// ===== hw/rtl/accel_tilt_angle_estimator_macros.svh =====
// Assertion helpers, sampled on clk, off while rst_n is low.
`ifndef ACCEL_TILT_ANGLE_ESTIMATOR_MACROS_SVH
`define ACCEL_TILT_ANGLE_ESTIMATOR_MACROS_SVH

// cond in a cycle implies prop in the same cycle
`define ATAE_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond in a cycle implies prop in the next cycle
`define ATAE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hw/rtl/atae_pkg.sv =====
package atae_pkg;

    // config register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd3;

    localparam int DIFF_W    = 18;
    localparam int WEIGHT_W  = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd52429;

    // yaw: round(|g|*128/131) by reciprocal multiply plus one correction
    localparam int YAW_NUM_W  = 23;
    localparam int YAW_PROD_W = 46;
    localparam int YAW_RECIP_SHIFT = 30;
    localparam logic [YAW_NUM_W-1:0] YAW_RECIP = 23'd8196502;
    localparam logic [YAW_NUM_W-1:0] YAW_ROUND = 23'd65;
    localparam logic [23:0] YAW_DIV = 24'd131;

    // angle datapath
    localparam int WORK_W = 24;
    localparam int SUM_W  = 48;
    localparam int ROOT_W = 49;
    localparam int MAG_W  = 24;
    localparam int CORD_W = 28;
    localparam int ANG_W  = 27;
    localparam int CNT_W  = 5;
    localparam int ANG_SHIFT = 9;
    localparam int PITCH_MAX = 11520;
    localparam int ROLL_MAX  = 23040;
    localparam int ROLL_MIN_Z = 104858;
    localparam logic [SUM_W-1:0] PITCH_MIN_SUM = 48'd10995116278;
    localparam logic [SUM_W-1:0] SQRT_TOP_BIT  = 48'h4000_0000_0000;
    localparam int SQRT_STEPS = 24;
    localparam int FILT_STEPS = 17;
    localparam logic signed [ANG_W-1:0] ANG_HALF_TURN = 27'sd11796480;
    localparam logic signed [ANG_W-1:0] ANG_RND       = 27'sd256;

    localparam int ATAN_DEPTH = 24;
    localparam logic [21:0] ATAN_TAB [ATAN_DEPTH] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff_x;
        logic signed [DIFF_W-1:0] diff_y;
        logic signed [DIFF_W-1:0] diff_z;
        logic [WEIGHT_W-1:0]      weight;
        logic                     yaw_neg;
        logic [YAW_NUM_W-1:0]     yaw_num;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT,
        ST_FUPD,
        ST_SQUARE,
        ST_SUM,
        ST_SQRT,
        ST_CINIT,
        ST_CRUN,
        ST_CEND,
        ST_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/atae_front.sv =====
module atae_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atae_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atae_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [15:0]               accel_x,
    input  logic signed [15:0]               accel_y,
    input  logic signed [15:0]               accel_z,
    input  logic signed [15:0]               gyro_z,
    output atae_pkg::item_t                  item
);
    import atae_pkg::*;

    logic signed [15:0]       off_x_reg;
    logic signed [15:0]       off_y_reg;
    logic signed [16:0]       off_z_reg;
    logic [WEIGHT_W-1:0]      weight_reg;
    logic [15:0]              gyro_abs;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_x_reg  <= '0;
            off_y_reg  <= '0;
            off_z_reg  <= '0;
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OFFSET_X:      off_x_reg  <= cfg_data[15:0];
                REG_OFFSET_Y:      off_y_reg  <= cfg_data[15:0];
                REG_OFFSET_Z:      off_z_reg  <= cfg_data[16:0];
                REG_FILTER_WEIGHT: weight_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // offset removal, weight saturation, yaw numerator
    always_comb
    begin
        gyro_abs = gyro_z[15] ? 16'(-gyro_z) : gyro_z;
        item.diff_x  = DIFF_W'(accel_x) - DIFF_W'(off_x_reg);
        item.diff_y  = DIFF_W'(accel_y) - DIFF_W'(off_y_reg);
        item.diff_z  = DIFF_W'(accel_z) - DIFF_W'(off_z_reg);
        item.weight  = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
        item.yaw_neg = gyro_z[15];
        item.yaw_num = {gyro_abs, 7'd0} + YAW_ROUND;
    end

endmodule

// ===== hw/rtl/atae_queue.sv =====
module atae_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                pop,
    input  atae_pkg::item_t     din,
    output atae_pkg::item_t     dout,
    output atae_pkg::q_status_t status
);
    import atae_pkg::*;

    item_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/atae_back.sv =====
module atae_back #(
    parameter int CORDIC_STEPS      = 16,
    parameter int FILTER_EXTRA_BITS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               q_pop,
    input  atae_pkg::item_t    head,
    input  logic               pop,
    output logic               empty,
    output logic signed [14:0] pitch,
    output logic signed [15:0] roll,
    output logic signed [15:0] z_rate
);
    import atae_pkg::*;

    localparam int FW = 18 + FILTER_EXTRA_BITS;
    localparam int DW = FW + 1;
    localparam int PW = DW + WEIGHT_W;
    localparam int XW = FW + 6;
    localparam int NSTEP = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic sel_reg;
    logic out_valid_reg;

    logic signed [FW-1:0] f_x_reg, f_y_reg, f_z_reg;
    logic signed [PW-1:0] d_x_reg, d_y_reg, d_z_reg;
    logic signed [PW-1:0] p_x_reg, p_y_reg, p_z_reg;
    logic [WEIGHT_W-1:0]  w_reg;
    logic                 yaw_neg_reg;
    logic [YAW_NUM_W-1:0] yaw_num_reg;
    logic [YAW_PROD_W-1:0] yprod_reg;
    logic signed [15:0]   yaw_reg;

    logic signed [WORK_W-1:0] wx_reg, wy_reg, wz_reg;
    logic [SUM_W-1:0]     ysq_reg, zsq_reg;
    logic [SUM_W-1:0]     v_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [SUM_W-1:0]     bit_reg;
    logic                 pitch_en_reg, roll_en_reg;

    logic signed [CORD_W-1:0] cx_reg, cy_reg;
    logic signed [ANG_W-1:0]  acc_reg;
    logic signed [14:0]   pitch_res_reg;
    logic signed [15:0]   roll_res_reg;
    logic signed [14:0]   pitch_out_reg;
    logic signed [15:0]   roll_out_reg;
    logic signed [15:0]   yaw_out_reg;

    // strobes
    logic filt_last, sqrt_last, crun_last, cur_en, out_load;

    // comb datapath
    logic signed [WORK_W-1:0] wx_c, wy_c, wz_c;
    logic signed [2*WORK_W-1:0] ysq_c, zsq_c;
    logic [SUM_W-1:0]     sum_c;
    logic [15:0]          yq0_c, yq_c;
    logic [23:0]          yrem_c;
    logic [ROOT_W-1:0]    trial_c;
    logic signed [CORD_W-1:0] dx_c, dy_c;
    logic signed [ANG_W-1:0]  tab_c, ang_c;

    function automatic logic signed [PW-1:0] diff_of(logic signed [DIFF_W-1:0] dv,
                                                     logic signed [FW-1:0] f);
        logic signed [FW-1:0] s;
        s = FW'(dv) <<< FILTER_EXTRA_BITS;
        return PW'(s) - PW'(f);
    endfunction

    function automatic logic signed [FW-1:0] upd(logic signed [FW-1:0] f,
                                                 logic signed [PW-1:0] p);
        logic signed [PW-1:0] rnd;
        logic signed [PW-1:0] t;
        logic signed [PW-1:0] sum;
        rnd = PW'(32'sd32768);
        t = (p + rnd) >>> 16;
        sum = PW'(f) + t;
        return sum[FW-1:0];
    endfunction

    // filter format to 2^20 per g
    function automatic logic signed [WORK_W-1:0] to_work(logic signed [FW-1:0] f);
        logic signed [XW-1:0] e;
        e = XW'(f) <<< 6;
        e = e >>> FILTER_EXTRA_BITS;
        return e[WORK_W-1:0];
    endfunction

    assign filt_last = (cnt_reg == CNT_W'(FILT_STEPS - 1));
    assign sqrt_last = (cnt_reg == CNT_W'(SQRT_STEPS - 1));
    assign crun_last = (cnt_reg == CNT_W'(NSTEP - 1));
    assign cur_en    = sel_reg ? roll_en_reg : pitch_en_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (!q_empty) state_next = ST_FILT;
            ST_FILT:   if (filt_last) state_next = ST_FUPD;
            ST_FUPD:   state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:    state_next = ST_SQRT;
            ST_SQRT:   if (sqrt_last) state_next = ST_CINIT;
            ST_CINIT:
            begin
                if (cur_en)
                    state_next = ST_CRUN;
                else if (sel_reg)
                    state_next = ST_OUT;
            end
            ST_CRUN:   if (crun_last) state_next = ST_CEND;
            ST_CEND:   state_next = sel_reg ? ST_OUT : ST_CINIT;
            ST_OUT:    if (!out_valid_reg) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: q_pop    = !q_empty;
            ST_OUT:  out_load = !out_valid_reg;
            default: ;
        endcase
    end

    always_comb
    begin
        wx_c  = to_work(f_x_reg);
        wy_c  = to_work(f_y_reg);
        wz_c  = to_work(f_z_reg);
        ysq_c = wy_c * wy_c;
        zsq_c = wz_c * wz_c;
        sum_c = ysq_reg + zsq_reg;
        yq0_c = yprod_reg[YAW_RECIP_SHIFT +: 16];
        yrem_c = 24'(yaw_num_reg) - 24'(yq0_c) * YAW_DIV;
        yq_c  = (yrem_c >= YAW_DIV) ? 16'(yq0_c + 1'b1) : yq0_c;
        trial_c = root_reg + ROOT_W'(bit_reg);
        dx_c  = cy_reg >>> cnt_reg;
        dy_c  = cx_reg >>> cnt_reg;
        tab_c = signed'(ANG_W'(ATAN_TAB[cnt_reg]));
        ang_c = (acc_reg + ANG_RND) >>> ANG_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            f_x_reg       <= '0;
            f_y_reg       <= '0;
            f_z_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: cnt_reg <= '0;
                ST_FILT: cnt_reg <= filt_last ? '0 : CNT_W'(cnt_reg + 1'b1);
                ST_FUPD:
                begin
                    f_x_reg <= upd(f_x_reg, p_x_reg);
                    f_y_reg <= upd(f_y_reg, p_y_reg);
                    f_z_reg <= upd(f_z_reg, p_z_reg);
                end
                ST_SUM:  cnt_reg <= '0;
                ST_SQRT:
                begin
                    cnt_reg <= sqrt_last ? '0 : CNT_W'(cnt_reg + 1'b1);
                    sel_reg <= 1'b0;
                end
                ST_CINIT:
                begin
                    cnt_reg <= '0;
                    if (!cur_en)
                        sel_reg <= 1'b1;
                end
                ST_CRUN: cnt_reg <= crun_last ? '0 : CNT_W'(cnt_reg + 1'b1);
                ST_CEND: sel_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    d_x_reg     <= diff_of(head.diff_x, f_x_reg);
                    d_y_reg     <= diff_of(head.diff_y, f_y_reg);
                    d_z_reg     <= diff_of(head.diff_z, f_z_reg);
                    p_x_reg     <= '0;
                    p_y_reg     <= '0;
                    p_z_reg     <= '0;
                    w_reg       <= head.weight;
                    yaw_neg_reg <= head.yaw_neg;
                    yaw_num_reg <= head.yaw_num;
                end
            end
            ST_FILT:
            begin
                // shift-add multiply by weight, one weight bit per cycle
                if (w_reg[0])
                begin
                    p_x_reg <= p_x_reg + d_x_reg;
                    p_y_reg <= p_y_reg + d_y_reg;
                    p_z_reg <= p_z_reg + d_z_reg;
                end
                d_x_reg <= d_x_reg <<< 1;
                d_y_reg <= d_y_reg <<< 1;
                d_z_reg <= d_z_reg <<< 1;
                w_reg   <= w_reg >> 1;
            end
            ST_FUPD:
            begin
                yprod_reg <= YAW_PROD_W'(yaw_num_reg) * YAW_PROD_W'(YAW_RECIP);
            end
            ST_SQUARE:
            begin
                wx_reg  <= wx_c;
                wy_reg  <= wy_c;
                wz_reg  <= wz_c;
                ysq_reg <= ysq_c[SUM_W-1:0];
                zsq_reg <= zsq_c[SUM_W-1:0];
                yaw_reg <= yaw_neg_reg ? 16'(-yq_c) : yq_c;
            end
            ST_SUM:
            begin
                v_reg        <= sum_c;
                root_reg     <= '0;
                bit_reg      <= SQRT_TOP_BIT;
                pitch_en_reg <= (sum_c >= PITCH_MIN_SUM);
                roll_en_reg  <= (wz_reg >= WORK_W'(ROLL_MIN_Z)) ||
                                (wz_reg <= -WORK_W'(ROLL_MIN_Z));
            end
            ST_SQRT:
            begin
                if (ROOT_W'(v_reg) >= trial_c)
                begin
                    v_reg    <= SUM_W'(ROOT_W'(v_reg) - trial_c);
                    root_reg <= (root_reg >> 1) + ROOT_W'(bit_reg);
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            ST_CINIT:
            begin
                if (!cur_en)
                begin
                    if (sel_reg)
                        roll_res_reg <= '0;
                    else
                        pitch_res_reg <= '0;
                end
                else if (!sel_reg)
                begin
                    cx_reg  <= CORD_W'({1'b0, root_reg[MAG_W-1:0]});
                    cy_reg  <= -CORD_W'(wx_reg);
                    acc_reg <= '0;
                end
                else if (wz_reg < 0)
                begin
                    // left half plane: rotate by half a turn first
                    cx_reg  <= -CORD_W'(wz_reg);
                    cy_reg  <= -CORD_W'(wy_reg);
                    acc_reg <= (wy_reg >= 0) ? ANG_HALF_TURN : -ANG_HALF_TURN;
                end
                else
                begin
                    cx_reg  <= CORD_W'(wz_reg);
                    cy_reg  <= CORD_W'(wy_reg);
                    acc_reg <= '0;
                end
            end
            ST_CRUN:
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg  <= cx_reg + dx_c;
                    cy_reg  <= cy_reg - dy_c;
                    acc_reg <= acc_reg + tab_c;
                end
                else
                begin
                    cx_reg  <= cx_reg - dx_c;
                    cy_reg  <= cy_reg + dy_c;
                    acc_reg <= acc_reg - tab_c;
                end
            end
            ST_CEND:
            begin
                if (sel_reg)
                begin
                    if (ang_c > ROLL_MAX)
                        roll_res_reg <= 16'(ROLL_MAX);
                    else if (ang_c < -ROLL_MAX)
                        roll_res_reg <= 16'(-ROLL_MAX);
                    else
                        roll_res_reg <= ang_c[15:0];
                end
                else
                begin
                    if (ang_c > PITCH_MAX)
                        pitch_res_reg <= 15'(PITCH_MAX);
                    else if (ang_c < -PITCH_MAX)
                        pitch_res_reg <= 15'(-PITCH_MAX);
                    else
                        pitch_res_reg <= ang_c[14:0];
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    pitch_out_reg <= pitch_res_reg;
                    roll_out_reg  <= roll_res_reg;
                    yaw_out_reg   <= yaw_reg;
                end
            end
            default: ;
        endcase
    end

    assign empty  = !out_valid_reg;
    assign pitch  = pitch_out_reg;
    assign roll   = roll_out_reg;
    assign z_rate = yaw_out_reg;

endmodule

// ===== hw/rtl/accel_tilt_angle_estimator.sv =====
// Tilt estimator: pitch, roll and Z turn rate from one accelerometer/gyro sample.
// Input side is a queue: an item (accel_x/y/z, gyro_z) is taken on push && !full.
// The front removes the axis offsets, saturates the filter weight and builds the
// yaw numerator, then parks the item in a two-entry queue.
// The back pops one item at a time: a shift-add low-pass update of all
// three axes, squares, a 24-step bit-serial square root, and one shared CORDIC
// unit run for pitch then roll (min(CORDIC_STEPS, 24) iterations each, skipped
// when the denominator is too small). Yaw uses a reciprocal multiply with one
// correction. The back takes no new item until the last result is loaded into
// the result register; an item waiting in the queue also waits for the one
// ahead of it.
// Result side is a single register: a result shows while empty is low, taken on
// pop && !empty. A stalled result holds; the back finishes the next item and
// waits, the queue takes two more, then full rises.
// Config writes (cfg_valid, always ready) load offsets and weight; index past
// the list is ignored. Reset clears filter state and offsets, weight to 52429.
`include "accel_tilt_angle_estimator_macros.svh"

module accel_tilt_angle_estimator #(
    parameter int CORDIC_STEPS      = 16,
    parameter int FILTER_EXTRA_BITS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atae_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [atae_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic signed [15:0]               accel_x,
    input  logic signed [15:0]               accel_y,
    input  logic signed [15:0]               accel_z,
    input  logic signed [15:0]               gyro_z,
    output logic                             empty,
    input  logic                             pop,
    output logic signed [14:0]               pitch,
    output logic signed [15:0]               roll,
    output logic signed [15:0]               z_rate
);
    import atae_pkg::*;

    item_t     front_item;
    item_t     head_item;
    q_status_t q_status;
    logic      q_pop;
    logic      q_empty;

    assign full    = q_status.full;
    assign q_empty = q_status.empty;

    // front: config registers, offset removal, weight saturation, yaw numerator
    atae_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .gyro_z    (gyro_z),
        .item      (front_item)
    );

    // decoupling queue between front and back
    atae_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (q_pop),
        .din    (front_item),
        .dout   (head_item),
        .status (q_status)
    );

    // back: filter, magnitude, CORDIC, yaw, result register
    atae_back #(
        .CORDIC_STEPS      (CORDIC_STEPS),
        .FILTER_EXTRA_BITS (FILTER_EXTRA_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .head     (head_item),
        .pop      (pop),
        .empty    (empty),
        .pitch    (pitch),
        .roll     (roll),
        .z_rate   (z_rate)
    );

    `ATAE_ASSERT_IMPL(a_no_pop_empty, q_pop, !q_empty, "back popped an empty queue")
    `ATAE_ASSERT_NEXT(a_push_lands, push && !full, !q_empty, "accepted item lost")
    `ATAE_ASSERT_IMPL(a_full_has_items, full, !q_empty, "queue full and empty")

endmodule

// ===== test/tb_accel_tilt_angle_estimator.sv =====
`timescale 1ns / 100ps

module tb_accel_tilt_angle_estimator;
    import atae_pkg::*;

    // Predictor constants (default build parameters)
    localparam int STEPS      = 16;
    localparam int EXTRA_BITS = 6;
    localparam int RAND_ITEMS = 1150;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam longint ATAN_STEP [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic signed [15:0] ax, ay, az, gz;
        bit                 known;  // expected result typed in below
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
    } row_t;

    typedef struct {
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
    } angles_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic push;
    logic full;
    logic signed [15:0] accel_x, accel_y, accel_z, gyro_z;
    logic empty;
    logic pop;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
    logic signed [15:0] z_rate;

    accel_tilt_angle_estimator DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .gyro_z(gyro_z),
        .empty(empty), .pop(pop),
        .pitch(pitch), .roll(roll), .z_rate(z_rate)
    );

    // Predictor's copy of registers and filter state
    longint off_x, off_y, off_z, weight;
    longint filt_x, filt_y, filt_z;

    angles_t pending_angles [$];
    int      errors;
    longint  cycles;
    bit      pop_enable;    // receiver stall pattern runs only when set

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_accel_tilt_angle_estimator: FAIL");
            $finish;
        end
    end

    // floor(v / 2^n)
    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v) r--;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // atan2(y, x) in 1/128 degree, clamped to +-lim
    function automatic longint angle_of(longint y, longint x, longint lim);
        longint acc, dx, dy, r;
        acc = 0;
        if (x < 0)
        begin
            acc = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx; y -= dy; acc += ATAN_STEP[i];
            end
            else
            begin
                x -= dx; y += dy; acc -= ATAN_STEP[i];
            end
        end
        r = floor_shift(acc + 256, ANG_SHIFT);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint lowpass(longint f, longint raw, longint off, longint w);
        longint s;
        s = (raw - off) * (64'sd1 <<< EXTRA_BITS);
        return floor_shift(w * s + (65536 - w) * f + 32768, 16);
    endfunction

    // Advances the filter state and returns the expected angles
    function automatic angles_t tilt_of(longint ax, longint ay, longint az, longint gz);
        angles_t a;
        longint w, x, y, z, sum, p, r, yw;
        w = (weight > 65536) ? 65536 : weight;
        filt_x = lowpass(filt_x, ax, off_x, w);
        filt_y = lowpass(filt_y, ay, off_y, w);
        filt_z = lowpass(filt_z, az, off_z, w);
        x = filt_x;  // 2^20 per g at six extra bits
        y = filt_y;
        z = filt_z;
        p = 0;
        r = 0;
        sum = y * y + z * z;
        if (sum * 100 > (64'sd1 <<< 40))
            p = angle_of(-x, root_floor(sum), PITCH_MAX);
        if (z >= ROLL_MIN_Z || z <= -ROLL_MIN_Z)
            r = angle_of(y, z, ROLL_MAX);
        if (gz >= 0) yw = (gz * 128 + 65) / 131;
        else yw = -((-gz * 128 + 65) / 131);
        a.pitch = p[14:0];
        a.roll  = r[15:0];
        a.yaw   = yw[15:0];
        return a;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Result checker and receiver stalls
    always @(posedge clk)
    begin
        angles_t e;
        if (rst_n && pop && !empty)
        begin
            if (pending_angles.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                e = pending_angles.pop_front();
                if (pitch !== e.pitch)
                    report_mismatch("pitch", longint'(pitch), longint'(e.pitch));
                if (roll !== e.roll)
                    report_mismatch("roll", longint'(roll), longint'(e.roll));
                if (z_rate !== e.yaw)
                    report_mismatch("z_rate", longint'(z_rate), longint'(e.yaw));
            end
        end
        // stall pattern: long open runs, then a stretch of random one-in-four stalls
        if (!pop_enable) pop <= 1'b0;
        else if (cycles % 2048 < 900) pop <= 1'b1;
        else pop <= ($urandom_range(3, 0) != 0);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_OFFSET_X:      off_x  = longint'($signed(val[15:0]));
            REG_OFFSET_Y:      off_y  = longint'($signed(val[15:0]));
            REG_OFFSET_Z:      off_z  = longint'($signed(val[16:0]));
            REG_FILTER_WEIGHT: weight = longint'(val);
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Sends one item with random burst gaps; predicts at acceptance
    task automatic send_sample(row_t rw);
        angles_t a;
        if ($urandom_range(5, 0) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(40, 1)) @(posedge clk);
        end
        push    <= 1'b1;
        accel_x <= rw.ax;
        accel_y <= rw.ay;
        accel_z <= rw.az;
        gyro_z  <= rw.gz;
        @(posedge clk);
        while (full) @(posedge clk);
        a = tilt_of(longint'(rw.ax), longint'(rw.ay), longint'(rw.az), longint'(rw.gz));
        if (rw.known)
        begin
            if (a.pitch !== rw.pitch || a.roll !== rw.roll || a.yaw !== rw.yaw)
                report_mismatch("table row", longint'(a.yaw), longint'(rw.yaw));
        end
        pending_angles.push_back(a);
    endtask

    // Ends the burst, waits for every result, then lets the back end settle
    task automatic drain();
        push <= 1'b0;
        while (pending_angles.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic row_t row(int ax, int ay, int az, int gz);
        row_t rw;
        rw.ax = 16'(ax); rw.ay = 16'(ay); rw.az = 16'(az); rw.gz = 16'(gz);
        rw.known = 1'b0;
        rw.pitch = '0; rw.roll = '0; rw.yaw = '0;
        return rw;
    endfunction

    function automatic row_t rand_row(bit realistic);
        row_t rw;
        if (realistic)
            rw = row($urandom_range(40000, 0) - 20000, $urandom_range(40000, 0) - 20000,
                     $urandom_range(40000, 0) - 20000, int'($signed(16'($urandom()))));
        else
            rw = row(int'($signed(16'($urandom()))), int'($signed(16'($urandom()))),
                     int'($signed(16'($urandom()))), int'($signed(16'($urandom()))));
        return rw;
    endfunction

    initial
    begin
        row_t table_rows [$];
        row_t rw;
        errors = 0;
        pop_enable = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        push = 1'b0;
        accel_x = '0; accel_y = '0; accel_z = '0; gyro_z = '0;
        off_x = 0; off_y = 0; off_z = 0; weight = 52429;
        filt_x = 0; filt_y = 0; filt_z = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        pop_enable = 1'b1;

        // Directed table. First row after reset: all zero except yaw extremes.
        rw = row(0, 0, 0, 32767);
        rw.known = 1'b1; rw.yaw = 16'sd32017;
        table_rows.push_back(rw);
        rw = row(0, 0, 0, -32768);
        rw.known = 1'b1; rw.yaw = -16'sd32018;
        table_rows.push_back(rw);
        rw = row(0, 0, 0, 0);
        rw.known = 1'b1;
        table_rows.push_back(rw);
        table_rows.push_back(row(0, 0, 16384, 131));
        table_rows.push_back(row(0, 0, 16384, -131));
        table_rows.push_back(row(16384, 0, 0, 1));     // small pitch denominator
        table_rows.push_back(row(0, 16384, 0, -1));    // small Z
        table_rows.push_back(row(0, 0, -16384, 65));   // negative abscissa
        table_rows.push_back(row(0, 0, -32768, 66));   // y=0, x<0: half turn
        table_rows.push_back(row(32767, 32767, 32767, 0));
        table_rows.push_back(row(-32768, -32768, -32768, 0));
        table_rows.push_back(row(-32768, 32767, -32768, 100));
        table_rows.push_back(row(1638, 1638, 1638, -100));
        foreach (table_rows[i]) send_sample(table_rows[i]);
        drain();

        // Weight above one saturates; weight one passes raw samples through
        write_reg(REG_FILTER_WEIGHT, 17'h1FFFF);
        write_reg(REG_OFFSET_Z, 17'h10000);            // most negative Z offset
        write_reg(REG_UNUSED, 17'h0);                  // index past the list
        send_sample(row(0, 0, 0, 0));
        send_sample(row(32767, -32768, 32767, 7));
        send_sample(row(100, 0, 0, 7));
        drain();

        // Random phases across register settings, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(REG_OFFSET_X, 17'h8000); write_reg(REG_OFFSET_Y, 17'h7FFF);
                    write_reg(REG_OFFSET_Z, 17'h0FFFF - 17'h0C000);
                    write_reg(REG_FILTER_WEIGHT, 17'd0);
                end
                1: begin
                    write_reg(REG_OFFSET_X, 17'd0); write_reg(REG_OFFSET_Y, 17'd0);
                    write_reg(REG_OFFSET_Z, 17'h0C000); write_reg(REG_FILTER_WEIGHT, 17'd65536);
                end
                2: begin
                    write_reg(REG_OFFSET_Z, 17'h3FFF); write_reg(REG_FILTER_WEIGHT, 17'd1);
                end
                3: begin
                    write_reg(REG_OFFSET_Z, 17'd0); write_reg(REG_FILTER_WEIGHT, 17'd52429);
                end
                default: begin
                    write_reg(REG_OFFSET_X, CFG_DATA_W'($urandom()));
                    write_reg(REG_OFFSET_Y, CFG_DATA_W'($urandom()));
                    write_reg(REG_OFFSET_Z,
                              CFG_DATA_W'($urandom_range(81919, 16384) - 16384 + 65536));
                    write_reg(REG_FILTER_WEIGHT, CFG_DATA_W'($urandom_range(70000, 0)));
                end
            endcase
            for (int k = 0; k < RAND_ITEMS / 8; k++)
                send_sample(rand_row($urandom_range(3, 0) != 0));
            drain();
        end

        if (errors == 0)
            $display("tb_accel_tilt_angle_estimator: PASS");
        else
            $display("tb_accel_tilt_angle_estimator: FAIL");
        $finish;
    end

endmodule
